// File: rtl/tap_pkg.sv
// ----------------------------------------------------------------------------
// tap_pkg
// Shared widths, register indexes, reset values and types of the tile
// average pixelator.
// ----------------------------------------------------------------------------
package tap_pkg;

  localparam int unsigned NumCh  = 3;   // color channels per pixel
  localparam int unsigned PixW   = 8;   // bits per channel
  localparam int unsigned SumW   = 22;  // per-tile channel sum
  localparam int unsigned CntW   = 20;  // pixel count of one tile
  localparam int unsigned PosW   = 12;  // column and row position
  localparam int unsigned DimW   = 13;  // image width and height registers
  localparam int unsigned HalfW  = 7;   // half tile register
  localparam int unsigned SideW  = 8;   // tile side, up to 128
  localparam int unsigned RibW   = 7;   // row within band
  localparam int unsigned ColW   = 6;   // tile_column field
  localparam int unsigned BandW  = 11;  // tile_row field
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned DefMaxTileColumns = 64;
  localparam int unsigned DefMaxDimension   = 4096;
  localparam int unsigned DefMaxHalfTile    = 64;

  localparam logic [CfgIdxW-1:0] CfgHalfTile    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd2;

  localparam logic [HalfW-1:0] RstHalfTile    = 7'd8;
  localparam logic [DimW-1:0]  RstImageWidth  = 13'd640;
  localparam logic [DimW-1:0]  RstImageHeight = 13'd480;

  typedef logic [NumCh-1:0][SumW-1:0] sums_t;

endpackage

// File: rtl/tap_mem.sv
// ----------------------------------------------------------------------------
// tap_mem
// Per-tile sum memory: one write and one registered read port, with a valid
// bit per entry so that a single clear_i empties every entry.
// ----------------------------------------------------------------------------
module tap_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output tap_pkg::sums_t     rd_data_o,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  tap_pkg::sums_t     wr_data_i
);
  import tap_pkg::*;

  sums_t             mem [Depth];
  sums_t             rd_data_q;
  logic              rd_vld_q;
  logic [Depth-1:0]  valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i] && !clear_i;
      end
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // entries never written since the last clear read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: rtl/tap_div.sv
// ----------------------------------------------------------------------------
// tap_div
// Restoring divider, one quotient bit per cycle, one lane per channel with a
// shared divisor. Quotients and the lane zero remainder hold until restart.
// ----------------------------------------------------------------------------
module tap_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  tap_pkg::sums_t            dividend_i,
  input  logic [tap_pkg::CntW-1:0]  divisor_i,
  output logic                      done_o,
  output tap_pkg::sums_t            quot_o,
  output logic [tap_pkg::CntW-1:0]  rem_o
);
  import tap_pkg::*;

  localparam int unsigned StepW = $clog2(SumW);

  sums_t                   dvd_q;
  logic [NumCh-1:0][CntW-1:0] rem_q;
  logic [CntW-1:0]         dsr_q;
  logic [StepW-1:0]        step_q;
  logic                    busy_q;
  logic                    done_q;

  sums_t                   dvd_d;
  logic [NumCh-1:0][CntW-1:0] rem_d;

  always_comb begin
    logic [CntW:0] trial;
    for (int l = 0; l < NumCh; l++) begin
      trial = {rem_q[l], dvd_q[l][SumW-1]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d[l] = CntW'(trial - {1'b0, dsr_q});
        dvd_d[l] = {dvd_q[l][SumW-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[CntW-1:0];
        dvd_d[l] = {dvd_q[l][SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q[0];

endmodule

// File: rtl/tile_average_pixelator_unit.sv
// ----------------------------------------------------------------------------
// tile_average_pixelator_unit
// Mosaic pixelation by block average: sums pixels per tile over a band of
// tile rows and emits one truncated mean per tile when the band completes.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata / data                      tuser / tlast
//  -------  ---------  --------------------------------  -------------------
//  s_axis   in         [7:0] ch0 [15:8] ch1 [23:16] ch2  tuser first_of_frame
//  m_axis   out        [7:0] mean0 [15:8] mean1          tlast last_in_band
//                      [23:16] mean2 [29:24] tile_column tuser last_of_frame
//                      [40:30] tile_row
//  cfg      in         index 0 half_tile, 1 width, 2 height
//
//  For each pixel the block reads its tile's sums from the memory, then
//  adds and writes them back; the next pixel is taken only after the write.
//  At band end the band index is divided out first; then each tile goes
//  through a read, a 22-step divide and an output load.
//  A config write is taken only while idle; the next pixel that does not
//  start a frame first clamps the position and re-derives its tile.
//  No clearing pass after reset: the sum memory has a valid bit per entry.
//  Input stalls while the block is busy or a register write is offered;
//  a pending result in the output register does not block pixel accumulation.
// ----------------------------------------------------------------------------
module tile_average_pixelator_unit #(
  parameter int unsigned MaxTileColumns = tap_pkg::DefMaxTileColumns,
  parameter int unsigned MaxDimension   = tap_pkg::DefMaxDimension,
  parameter int unsigned MaxHalfTile    = tap_pkg::DefMaxHalfTile
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tap_pkg::InDataW-1:0]   s_axis_tdata,   // ch0, ch1, ch2
  input  logic                          s_axis_tuser,   // first_of_frame
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tap_pkg::OutDataW-1:0]  m_axis_tdata,   // mean0..2, column, row
  output logic                          m_axis_tlast,   // last_in_band
  output logic                          m_axis_tuser,   // last_of_frame
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tap_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tap_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tap_pkg::*;

  localparam int unsigned TileW = (MaxTileColumns > 1) ? $clog2(MaxTileColumns) : 1;
  localparam logic [TileW-1:0] LastTile = TileW'(MaxTileColumns - 1);

  typedef enum logic [2:0] {
    StIdle, StFix, StFixDiv, StAcc, StBandDiv, StTileRd, StTileDiv, StTileOut
  } state_e;

  state_e            state_q;
  logic [HalfW-1:0]  half_q;
  logic [DimW-1:0]   width_q, height_q;
  logic [PosW-1:0]   col_q, row_q;
  logic [RibW-1:0]   rib_q, crem_q;
  logic [TileW-1:0]  tile_q, c_q;
  logic [NumCh-1:0][PixW-1:0] pix_q;
  logic [SideW-1:0]  rows_q;
  logic              fe_q, last_q;
  logic              fix_q;
  logic [BandW-1:0]  band_q;
  logic [DimW:0]     cstart_q;
  logic              m_valid_q, m_last_q, m_user_q;
  logic [OutDataW-1:0] m_data_q;

  // effective register values after range clamping
  logic [HalfW-1:0]  half_c;
  logic [SideW-1:0]  side;
  logic [DimW-1:0]   width_c, height_c;

  always_comb begin
    if (half_q == '0)                     half_c = HalfW'(1);
    else if (half_q > HalfW'(MaxHalfTile)) half_c = HalfW'(MaxHalfTile);
    else                                  half_c = half_q;
    if (width_q == '0)                      width_c = DimW'(1);
    else if (width_q > DimW'(MaxDimension)) width_c = DimW'(MaxDimension);
    else                                    width_c = width_q;
    if (height_q == '0)                      height_c = DimW'(1);
    else if (height_q > DimW'(MaxDimension)) height_c = DimW'(MaxDimension);
    else                                     height_c = height_q;
  end
  assign side = {half_c, 1'b0};

  // handshakes
  logic s_acc, cfg_acc, can_load;
  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign can_load = !m_valid_q || m_axis_tready;

  // memory and divider hookup
  logic              mem_clear, rd_en, wr_en;
  logic [TileW-1:0]  rd_addr;
  sums_t             rd_data, wr_data;
  logic              div_start, div_done;
  sums_t             div_dvd, div_quot;
  logic [CntW-1:0]   div_dsr, div_rem;

  // tile of the clamped column, clamped into the last tile
  logic [TileW-1:0]  fix_tile;
  assign fix_tile = (div_quot[0] > SumW'(LastTile)) ? LastTile : div_quot[0][TileW-1:0];

  // clamped positions after a register change
  logic [PosW-1:0]   col_fix, row_fix;
  logic [RibW-1:0]   rib_fix;
  always_comb begin
    col_fix = ({1'b0, col_q} >= width_c)  ? PosW'(width_c - 1'b1)  : col_q;
    row_fix = ({1'b0, row_q} >= height_c) ? PosW'(height_c - 1'b1) : row_q;
    rib_fix = ({1'b0, rib_q} >= side)     ? RibW'(side - 1'b1)     : rib_q;
  end

  // accumulate step: saturating adds and position advance
  logic [DimW-1:0]   col_next;
  logic              row_done, frame_end, band_end;
  always_comb begin
    logic [SumW:0] s;
    for (int l = 0; l < NumCh; l++) begin
      s = {1'b0, rd_data[l]} + {{(SumW-PixW+1){1'b0}}, pix_q[l]};
      wr_data[l] = s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
    end
    col_next  = {1'b0, col_q} + 1'b1;
    row_done  = (col_next >= width_c);
    frame_end = ({1'b0, row_q} + 1'b1 >= height_c);
    band_end  = frame_end || ({1'b0, rib_q} + 1'b1 >= side);
  end

  // tile geometry for emission
  logic              tile_last;
  logic [DimW-1:0]   tile_cols;
  logic [CntW:0]     tile_count;
  always_comb begin
    tile_last  = (c_q == LastTile) ||
                 ({1'b0, cstart_q} + {{(DimW-SideW+2){1'b0}}, side} >= {2'b0, width_c});
    tile_cols  = tile_last ? DimW'(width_c - cstart_q[DimW-1:0]) : DimW'(side);
    tile_count = (CntW+1)'(tile_cols * rows_q);
  end

  // truncated means, held by the divider
  logic [NumCh-1:0][PixW-1:0] means;
  always_comb begin
    for (int l = 0; l < NumCh; l++) begin
      means[l] = (div_quot[l] > SumW'(255)) ? {PixW{1'b1}} : div_quot[l][PixW-1:0];
    end
  end

  // memory port and divider start
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    mem_clear = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = CntW'(side);
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          rd_en     = 1'b1;
          rd_addr   = s_axis_tuser ? '0 : tile_q;
          mem_clear = s_axis_tuser;
        end
      end
      StFix: begin
        div_start  = 1'b1;
        div_dvd[0] = SumW'(col_fix);
      end
      StFixDiv: begin
        // fetch the sums of the re-derived tile
        rd_en   = div_done;
        rd_addr = fix_tile;
      end
      StAcc: begin
        wr_en = 1'b1;
        if (row_done && band_end) begin
          div_start  = 1'b1;
          div_dvd[0] = SumW'(row_q);
        end
      end
      StBandDiv: begin
        rd_en = div_done;
      end
      StTileRd: begin
        div_start = 1'b1;
        div_dvd   = rd_data;
        div_dsr   = tile_count[CntW-1:0];
      end
      StTileOut: begin
        if (can_load) begin
          rd_en     = !last_q;
          rd_addr   = c_q + 1'b1;
          mem_clear = last_q;
        end
      end
      default: ;
    endcase
  end

  tap_mem #(
    .Depth (MaxTileColumns),
    .AddrW (TileW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (mem_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (tile_q),
    .wr_data_i (wr_data)
  );

  tap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int l = 0; l < NumCh; l++) begin
        pix_q[l] <= s_axis_tdata[l*PixW +: PixW];
      end
    end
    if (state_q == StTileOut && can_load) begin
      m_data_q <= {{(OutDataW-NumCh*PixW-ColW-BandW){1'b0}},
                   band_q, ColW'(c_q), means[2], means[1], means[0]};
      m_last_q <= last_q;
      m_user_q <= last_q && fe_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      half_q    <= RstHalfTile;
      width_q   <= RstImageWidth;
      height_q  <= RstImageHeight;
      col_q     <= '0;
      row_q     <= '0;
      rib_q     <= '0;
      crem_q    <= '0;
      tile_q    <= '0;
      c_q       <= '0;
      cstart_q  <= '0;
      rows_q    <= '0;
      fe_q      <= 1'b0;
      last_q    <= 1'b0;
      fix_q     <= 1'b0;
      band_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // load a new result or drop the one just taken
      if (state_q == StTileOut && can_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cfg_acc) begin
            unique case (cfg_index_i)
              CfgHalfTile:    half_q   <= cfg_data_i[HalfW-1:0];
              CfgImageWidth:  width_q  <= cfg_data_i;
              CfgImageHeight: height_q <= cfg_data_i;
              default: ;
            endcase
            // clamp the positions when the next pixel arrives
            fix_q <= 1'b1;
          end else if (s_acc) begin
            // frame start drops any partial band
            if (s_axis_tuser) begin
              col_q   <= '0;
              row_q   <= '0;
              rib_q   <= '0;
              crem_q  <= '0;
              tile_q  <= '0;
              fix_q   <= 1'b0;
              state_q <= StAcc;
            end else if (fix_q) begin
              state_q <= StFix;
            end else begin
              state_q <= StAcc;
            end
          end
        end
        StFix: begin
          col_q   <= col_fix;
          row_q   <= row_fix;
          rib_q   <= rib_fix;
          state_q <= StFixDiv;
        end
        StFixDiv: begin
          if (div_done) begin
            tile_q  <= fix_tile;
            crem_q  <= div_rem[RibW-1:0];
            fix_q   <= 1'b0;
            state_q <= StAcc;
          end
        end
        StAcc: begin
          if (!row_done) begin
            col_q <= col_next[PosW-1:0];
            if ({1'b0, crem_q} + 1'b1 == side) begin
              crem_q <= '0;
              if (tile_q != LastTile) begin
                tile_q <= tile_q + 1'b1;
              end
            end else begin
              crem_q <= crem_q + 1'b1;
            end
            state_q <= StIdle;
          end else begin
            col_q  <= '0;
            crem_q <= '0;
            tile_q <= '0;
            if (!band_end) begin
              row_q   <= row_q + 1'b1;
              rib_q   <= rib_q + 1'b1;
              state_q <= StIdle;
            end else begin
              rows_q  <= {1'b0, rib_q} + 1'b1;
              fe_q    <= frame_end;
              state_q <= StBandDiv;
            end
          end
        end
        StBandDiv: begin
          if (div_done) begin
            band_q   <= div_quot[0][BandW-1:0];
            c_q      <= '0;
            cstart_q <= '0;
            state_q  <= StTileRd;
          end
        end
        StTileRd: begin
          last_q  <= tile_last;
          state_q <= StTileDiv;
        end
        StTileDiv: begin
          if (div_done) begin
            state_q <= StTileOut;
          end
        end
        StTileOut: begin
          if (can_load) begin
            if (last_q) begin
              rib_q   <= '0;
              row_q   <= fe_q ? '0 : row_q + 1'b1;
              state_q <= StIdle;
            end else begin
              c_q      <= c_q + 1'b1;
              cstart_q <= cstart_q + {{(DimW-SideW+1){1'b0}}, side};
              state_q  <= StTileRd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: rtl/tap_checker.sv
// ----------------------------------------------------------------------------
// tap_checker
// Port-level checks of the tile average pixelator, bound to the top level.
// ----------------------------------------------------------------------------
module tap_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tap_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // frame end only on the last tile of a band
  a_frame_in_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("last_of_frame without last_in_band");

  // a register write and a pixel are never taken on the same edge
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !(s_axis_tvalid && s_axis_tready))
    else $error("register write and pixel taken together");

endmodule

bind tile_average_pixelator_unit tap_checker u_tap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

// File: tb/sv/tb_tile_average_pixelator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tile_average_pixelator_unit
// Self-checking testbench of the tile average pixelator. Pixels are streamed
// in under several tile and image settings, a local model of the tile
// accumulator predicts every tile mean, and each result request is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tile_average_pixelator_unit;
  import tap_pkg::*;

  localparam int unsigned MaxCols = DefMaxTileColumns;
  localparam int unsigned SumMax  = 32'h3F_FFFF;

  typedef struct packed {
    logic [PixW-1:0]  mean_zero;
    logic [PixW-1:0]  mean_one;
    logic [PixW-1:0]  mean_two;
    logic [ColW-1:0]  tile_column;
    logic [BandW-1:0] tile_row;
    logic             last_in_band;
    logic             last_of_frame;
  } tile_mean_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // ch0, ch1, ch2
  logic                s_axis_tuser = 1'b0; // first_of_frame
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // mean0, mean1, mean2, column, row
  logic                m_axis_tlast;        // last_in_band
  logic                m_axis_tuser;        // last_of_frame
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tile_average_pixelator_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Register copies and accumulator state of the local tile model.
  int unsigned half_reg, width_reg, height_reg;
  int unsigned acc_zero [MaxCols];
  int unsigned acc_one  [MaxCols];
  int unsigned acc_two  [MaxCols];
  int unsigned col_pos, row_pos, band_row;

  tile_mean_t  pending_means[$];
  int          error_count = 0;
  int          pixels_sent = 0;
  int          means_seen = 0;
  bit          idle_on = 1'b1;   // random gaps on both sides
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned add_sat(input int unsigned a, input int unsigned b);
    return (a + b > SumMax) ? SumMax : a + b;
  endfunction

  task automatic clear_accumulators();
    for (int i = 0; i < MaxCols; i++) begin
      acc_zero[i] = 0;
      acc_one[i] = 0;
      acc_two[i] = 0;
    end
  endtask

  // Accumulate one accepted pixel and queue the tile means of a finished band.
  task automatic accumulate_pixel(input bit fof, input int unsigned c0, input int unsigned c1,
                                  input int unsigned c2);
    int unsigned side, width, height, tile, ntiles, rows, band, cols, cnt, m;
    bit frame_end, band_end;
    tile_mean_t tm;
    side = 2 * clamp_reg(half_reg, DefMaxHalfTile);
    width = clamp_reg(width_reg, DefMaxDimension);
    height = clamp_reg(height_reg, DefMaxDimension);
    if (fof) begin
      clear_accumulators();
      col_pos = 0;
      row_pos = 0;
      band_row = 0;
    end
    // Registers may have shrunk under a frame in progress: pull positions in.
    if (col_pos >= width) col_pos = width - 1;
    if (row_pos >= height) row_pos = height - 1;
    if (band_row >= side) band_row = side - 1;
    tile = col_pos / side;
    if (tile > MaxCols - 1) tile = MaxCols - 1;
    acc_zero[tile] = add_sat(acc_zero[tile], c0);
    acc_one[tile] = add_sat(acc_one[tile], c1);
    acc_two[tile] = add_sat(acc_two[tile], c2);
    col_pos++;
    if (col_pos < width) return;
    col_pos = 0;
    frame_end = (row_pos + 1 >= height);
    band_end = frame_end || (band_row + 1 >= side);
    if (!band_end) begin
      row_pos++;
      band_row++;
      return;
    end
    rows = band_row + 1;
    band = row_pos / side;
    ntiles = (width + side - 1) / side;
    if (ntiles > MaxCols) ntiles = MaxCols;
    for (int unsigned c = 0; c < ntiles; c++) begin
      cols = (c == ntiles - 1) ? width - c * side : side;
      cnt = cols * rows;
      m = acc_zero[c] / cnt;  tm.mean_zero = (m > 255) ? 8'hFF : m[7:0];
      m = acc_one[c] / cnt;   tm.mean_one  = (m > 255) ? 8'hFF : m[7:0];
      m = acc_two[c] / cnt;   tm.mean_two  = (m > 255) ? 8'hFF : m[7:0];
      tm.tile_column = c[ColW-1:0];
      tm.tile_row = band[BandW-1:0];
      tm.last_in_band = (c == ntiles - 1);
      tm.last_of_frame = (c == ntiles - 1) && frame_end;
      pending_means.push_back(tm);
    end
    clear_accumulators();
    band_row = 0;
    row_pos = frame_end ? 0 : row_pos + 1;
  endtask

  // Offer one pixel request, with an occasional idle burst ahead of it.
  task automatic send_pixel(input bit fof, input int unsigned c0, input int unsigned c1,
                            input int unsigned c2);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fof;
    s_axis_tdata <= {c2[7:0], c1[7:0], c0[7:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    accumulate_pixel(fof, c0, c1, c2);
    pixels_sent++;
  endtask

  task automatic send_random_pixel(input bit fof);
    send_pixel(fof, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // Hold the stream until every predicted mean has come, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgHalfTile:    half_reg = value & 32'h7F;
      CfgImageWidth:  width_reg = value & 32'h1FFF;
      CfgImageHeight: height_reg = value & 32'h1FFF;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned half, input int unsigned w, input int unsigned h);
    drain();
    write_reg(CfgHalfTile, half);
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
  endtask

  task automatic send_frame(input int unsigned npix);
    for (int i = 0; i < npix; i++) send_random_pixel(i == 0);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and checks.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  always @(posedge clk_i) begin
    tile_mean_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.mean_zero = m_axis_tdata[7:0];
      got.mean_one = m_axis_tdata[15:8];
      got.mean_two = m_axis_tdata[23:16];
      got.tile_column = m_axis_tdata[29:24];
      got.tile_row = m_axis_tdata[40:30];
      got.last_in_band = m_axis_tlast;
      got.last_of_frame = m_axis_tuser;
      means_seen++;
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pending_means.pop_front();
        if (got.mean_zero != want.mean_zero)
          report_mismatch($sformatf("mean_zero %0d want %0d", got.mean_zero, want.mean_zero));
        if (got.mean_one != want.mean_one)
          report_mismatch($sformatf("mean_one %0d want %0d", got.mean_one, want.mean_one));
        if (got.mean_two != want.mean_two)
          report_mismatch($sformatf("mean_two %0d want %0d", got.mean_two, want.mean_two));
        if (got.tile_column != want.tile_column)
          report_mismatch($sformatf("tile_column %0d want %0d", got.tile_column,
                                    want.tile_column));
        if (got.tile_row != want.tile_row)
          report_mismatch($sformatf("tile_row %0d want %0d", got.tile_row, want.tile_row));
        if (got.last_in_band != want.last_in_band)
          report_mismatch($sformatf("last_in_band %0b want %0b", got.last_in_band,
                                    want.last_in_band));
        if (got.last_of_frame != want.last_of_frame)
          report_mismatch($sformatf("last_of_frame %0b want %0b", got.last_of_frame,
                                    want.last_of_frame));
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // Tiny and maximal images: extreme pixel values and each register at zero, at its top or past it.
  task automatic test_extremes();
    set_geometry(1, 3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 0, (i % 2) ? 255 : 0, (i % 3) ? 0 : 255, 255 - i);
    set_geometry(0, 0, 0);                 // all act as 1: one pixel per frame
    send_pixel(1'b1, 255, 255, 255);
    send_pixel(1'b0, 0, 0, 0);
    send_pixel(1'b1, 170, 85, 1);
    set_geometry(127, 5, 2);               // half tile past its top
    send_frame(10);
    set_geometry(64, 4096, 4096);
    send_frame(20);
    set_geometry(127, 8191, 8191);         // widths past their top
    send_frame(5);
  endtask

  // Drop a partial band by starting a new frame in the middle of it.
  task automatic test_frame_restart();
    set_geometry(2, 6, 5);
    send_frame(9);
    send_frame(30);
  endtask

  // Shrink the registers under a frame in progress.
  task automatic test_midframe_change();
    set_geometry(2, 8, 6);
    send_frame(10);
    drain();
    write_reg(CfgImageWidth, 2);
    write_reg(CfgHalfTile, 1);
    for (int i = 0; i < 8; i++) send_random_pixel(1'b0);
    drain();
    write_reg(CfgImageHeight, 1);
    for (int i = 0; i < 6; i++) send_random_pixel(1'b0);
  endtask

  // Hold off the receiver while pixels keep coming, then pause the sender.
  task automatic test_backpressure();
    set_geometry(1, 16, 4);
    hold_req = 1'b1;
    send_frame(64);
    drain();
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned n, w, h;
    while (pixels_sent < target) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 20);
      h = (w > 20) ? $urandom_range(1, 2) : $urandom_range(1, 8);
      set_geometry($urandom_range(0, 5), w, h);
      repeat ($urandom_range(1, 2)) begin
        if (pixels_sent < target) begin
          n = w * h;
          if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);  // broken frame
          send_frame(n);
        end
      end
    end
  endtask

  task automatic test_tail();
    idle_on = 1'b0;
    set_geometry(2, 10, 5);
    send_frame(50);
    send_frame(50);
  endtask

  initial begin
    half_reg = RstHalfTile;
    width_reg = RstImageWidth;
    height_reg = RstImageHeight;
    clear_accumulators();
    col_pos = 0;
    row_pos = 0;
    band_row = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_extremes();
    test_frame_restart();
    test_midframe_change();
    test_backpressure();
    test_random(pixels_sent + 190);
    test_tail();
    drain();
    repeat (200) @(posedge clk_i);
    if (pending_means.size() != 0)
      report_mismatch($sformatf("%0d predicted means never arrived", pending_means.size()));
    $display("Covered: %0d pixels, %0d tile means, clipped and clamped tiles,", pixels_sent,
             means_seen);
    $display("frame restarts, register changes mid-frame and back-pressure.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d means pending", pending_means.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/tap_pkg.sv
rtl/tap_mem.sv
rtl/tap_div.sv
rtl/tile_average_pixelator_unit.sv
rtl/tap_checker.sv
tb/sv/tb_tile_average_pixelator_unit.sv
